>>> sv/lzsswd_pkg.sv
package lzsswd_pkg;

  localparam int WINDOW_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int PROD_W          = 24;
  localparam int PTR_START       = 'hfee;
  localparam int MIN_MATCH       = 3;

endpackage

>>> sv/lzss_window_decoder.sv
// A literal appears on out_* in the cycle after its beat is accepted; a match reads its
// first byte through the registered window read and puts it out through the output register,
// then one byte a cycle unless out_ready stalls it. Input is taken only while the output
// is free, and none after a second match byte until its 3 to 18 copied bytes are out.
// Reset (and start_stream) clear the control state; the window is never swept, a fill count
// makes every entry not yet written in the stream read as zero.
module lzss_window_decoder
  import lzsswd_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_start_stream,
  input  logic [7:0]        in_byte,
  input  logic              in_last_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic [PROD_W-1:0] out_produced_count
);

  localparam int WIN_DEPTH = 1 << WINDOW_BITS;
  localparam logic [WINDOW_BITS-1:0] PTR_INIT = WINDOW_BITS'(PTR_START);

  typedef enum logic [2:0] {
    PH_FLAG  = 3'b001,
    PH_ITEM  = 3'b010,
    PH_MATCH = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COPY = 2'b10
  } seq_t;

  logic [7:0] win_mem [WIN_DEPTH];

  seq_t                   st_r, st_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [8:0]             ctrl_r, ctrl_nxt;
  logic [7:0]             off_lo_r, off_lo_nxt;
  logic [WINDOW_BITS-1:0] wp_r, wp_nxt;
  logic [WINDOW_BITS:0]   fill_r, fill_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [WINDOW_BITS-1:0] src_r, src_nxt;
  logic [4:0]             len_r, len_nxt;
  logic                   hit_r, hit_nxt;
  logic [7:0]             hit_byte_r, hit_byte_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [COUNT_BITS-1:0]  out_cnt_r, out_cnt_nxt;

  logic [7:0]             rd_q;
  logic [WINDOW_BITS-1:0] rd_addr;
  logic                   mem_we;
  logic [WINDOW_BITS-1:0] mem_wa;
  logic [7:0]             mem_wd;

  logic                   out_free, accept, adv;
  phase_t                 phase_e;
  logic [8:0]             ctrl_e, ctrl_sh;
  logic [WINDOW_BITS-1:0] wp_e, src_dist, src_first;
  logic [WINDOW_BITS:0]   fill_e;
  logic [COUNT_BITS-1:0]  cnt_e;
  logic                   src_valid;
  logic [7:0]             cp_data;
  logic [COUNT_BITS+PROD_W-1:0] cnt_ext;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign adv      = (st_r == S_COPY) && out_free;

  // State seen by the accepted beat: stream-start clears, spent flag bytes go to PH_FLAG.
  always_comb begin
    ctrl_e  = in_start_stream ? 9'd0 : ctrl_r;
    wp_e    = in_start_stream ? PTR_INIT : wp_r;
    fill_e  = in_start_stream ? '0 : fill_r;
    cnt_e   = in_start_stream ? '0 : cnt_r;
    phase_e = phase_r;
    if (in_start_stream || (phase_r == PH_ITEM && ctrl_r <= 9'd1)) begin
      phase_e = PH_FLAG;
    end
  end

  assign ctrl_sh   = ctrl_e >> 1;
  assign src_first = {in_byte[7:4], off_lo_r};

  // An entry is valid once written since the stream began at PTR_INIT.
  assign src_dist  = src_r - PTR_INIT;
  assign src_valid = fill_r[WINDOW_BITS] || ({1'b0, src_dist} < fill_r);
  assign cp_data   = src_valid ? (hit_r ? hit_byte_r : rd_q) : 8'd0;

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    ctrl_nxt      = ctrl_r;
    off_lo_nxt    = off_lo_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    src_nxt       = src_r;
    len_nxt       = len_r;
    hit_nxt       = hit_r;
    hit_byte_nxt  = hit_byte_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    rd_addr       = src_r;
    mem_we        = 1'b0;
    mem_wa        = wp_r;
    mem_wd        = cp_data;

    if (accept) begin
      ctrl_nxt   = ctrl_e;
      wp_nxt     = wp_e;
      fill_nxt   = fill_e;
      cnt_nxt    = cnt_e;
      phase_nxt  = phase_e;
      if (in_start_stream) begin
        off_lo_nxt = 8'd0;
      end
      unique case (phase_e)
        PH_ITEM: begin
          if (ctrl_e[0]) begin
            mem_we        = 1'b1;
            mem_wa        = wp_e;
            mem_wd        = in_byte;
            wp_nxt        = wp_e + 1'b1;
            fill_nxt      = fill_e[WINDOW_BITS] ? fill_e : fill_e + 1'b1;
            cnt_nxt       = (&cnt_e) ? cnt_e : cnt_e + 1'b1;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = in_byte;
            out_last_nxt  = 1'b1;
            out_cnt_nxt   = cnt_nxt;
            ctrl_nxt      = ctrl_sh;
            phase_nxt     = (ctrl_sh > 9'd1) ? PH_ITEM : PH_FLAG;
          end else begin
            off_lo_nxt = in_byte;
            phase_nxt  = PH_MATCH;
          end
        end
        PH_MATCH: begin
          rd_addr   = src_first;
          src_nxt   = src_first;
          len_nxt   = {1'b0, in_byte[3:0]} + 5'(MIN_MATCH - 1);
          hit_nxt   = 1'b0;
          st_nxt    = S_COPY;
          ctrl_nxt  = ctrl_sh;
          phase_nxt = (ctrl_sh > 9'd1) ? PH_ITEM : PH_FLAG;
        end
        default: begin
          ctrl_nxt  = {1'b1, in_byte};
          phase_nxt = PH_ITEM;
        end
      endcase
      if (in_last_in) begin
        phase_nxt = PH_FLAG;
        ctrl_nxt  = 9'd0;
      end
    end else if (adv) begin
      // Emit one copied byte and write it back; forward it if the next read hits it.
      mem_we        = 1'b1;
      wp_nxt        = wp_r + 1'b1;
      fill_nxt      = fill_r[WINDOW_BITS] ? fill_r : fill_r + 1'b1;
      cnt_nxt       = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cp_data;
      out_last_nxt  = (len_r == 5'd0);
      out_cnt_nxt   = cnt_nxt;
      src_nxt       = src_r + 1'b1;
      rd_addr       = src_nxt;
      hit_nxt       = (src_nxt == wp_r);
      hit_byte_nxt  = cp_data;
      len_nxt       = len_r - 1'b1;
      if (len_r == 5'd0) begin
        st_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_wa] <= mem_wd;
    end
    rd_q <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_FLAG;
      ctrl_r      <= 9'd0;
      off_lo_r    <= 8'd0;
      wp_r        <= PTR_INIT;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      ctrl_r      <= ctrl_nxt;
      off_lo_r    <= off_lo_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    len_r      <= len_nxt;
    hit_byte_r <= hit_byte_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign cnt_ext            = {{PROD_W{1'b0}}, out_cnt_r};
  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_run_last       = out_last_r;
  assign out_produced_count = cnt_ext[PROD_W-1:0];

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> st_r == S_IDLE)
    else $error("input taken while a copy runs");

  a_copy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && len_r != 5'd0 |=> st_r == S_COPY)
    else $error("copy ended early");

  a_copy_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && len_r == 5'd0 |=> out_valid && out_run_last && st_r == S_IDLE)
    else $error("final copied byte not flagged");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_r[WINDOW_BITS] || fill_r[WINDOW_BITS-1:0] == '0)
    else $error("fill count past window size");

endmodule
